// ===== rtl/ltlm_pkg.sv =====
// ltlm_pkg: shared types for the linked task list manager.
// Holds the command codes, the sequencer states and the request/response beats.
// No dependencies.
`timescale 1ns / 1ps

package ltlm_pkg;

    // Field widths of the request and response beats
    localparam int CMD_W      = 3;
    localparam int ENTRY_W    = 6;
    localparam int CB_IN_W    = 4;
    localparam int POOL_CFG_W = 7;
    localparam logic [POOL_CFG_W-1:0] POOL_SIZE_RESET = 7'd64;

    // Command codes; the two unused codes act as query
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT       = 3'd0,
        CMD_INS_BEFORE = 3'd1,
        CMD_INS_AFTER  = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_MARK       = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    // Sequencer states; each busy state consumes the word read last cycle
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_INS_T,
        ST_INS_E,
        ST_INS_T2,
        ST_INS_NB,
        ST_RM_T,
        ST_RM_N,
        ST_RM_P,
        ST_RM_F,
        ST_MARK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ENTRY_W-1:0] entry;
        logic               entry_present;
        logic [CB_IN_W-1:0] callback_id;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [ENTRY_W-1:0] task_res;
        logic [ENTRY_W-1:0] head;
        logic               head_valid;
        logic [ENTRY_W-1:0] tail;
        logic [ENTRY_W-1:0] link_prev;
        logic               prev_valid;
        logic [ENTRY_W-1:0] link_next;
        logic               next_valid;
        logic [CB_IN_W-1:0] entry_callback;
    } rsp_t;

endpackage

// ===== rtl/ltlm_ram.sv =====
// ltlm_ram: generic simple dual-port RAM, one write and one registered read port.
// Read returns the old word when read and write hit the same address.
// No dependencies.
`timescale 1ns / 1ps

module ltlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/linked_task_list_manager.sv =====
// linked_task_list_manager: task pool with free list and doubly linked active list.
// Uses ltlm_pkg and one ltlm_ram holding {next, prev, callback} per entry.
// One item at a time; at most one link word is read-modified-written per cycle, and
// req_stall holds new requests until the current response beat is loaded. The next
// item is taken the cycle after its response is loaded.
// Reset clears free head and list ends to null and pool_size to 64; RAM is not cleared.
`timescale 1ns / 1ps

module linked_task_list_manager
    import ltlm_pkg::*;
#(
    parameter int MAX_ENTRIES   = 64,
    parameter int CALLBACK_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [POOL_CFG_W-1:0] cfg_data
);

    localparam int IDXW     = $clog2(MAX_ENTRIES);
    localparam int LW       = $clog2(MAX_ENTRIES + 1);
    localparam int CBW      = CALLBACK_BITS;
    localparam int PREV_LSB = CBW;
    localparam int NEXT_LSB = CBW + LW;
    localparam int WORD_W   = CBW + 2 * LW;
    localparam int CW       = (LW > POOL_CFG_W) ? LW : POOL_CFG_W;
    localparam logic [LW-1:0]  NIL         = LW'(MAX_ENTRIES);
    localparam logic [CBW-1:0] REMOVE_CODE = {CBW{1'b1}};
    localparam logic [CW-1:0]  MAX_EXT     = CW'(MAX_ENTRIES);

    // Helpers on links and callbacks
    function automatic logic is_idx(input logic [LW-1:0] l);
        return l < NIL;
    endfunction

    function automatic logic [LW-1:0] idx2link(input logic [IDXW-1:0] i);
        return LW'(i);
    endfunction

    function automatic logic [ENTRY_W-1:0] link6(input logic [LW-1:0] l);
        logic [LW+ENTRY_W-1:0] wide;
        wide = {{ENTRY_W{1'b0}}, l};
        return wide[ENTRY_W-1:0];
    endfunction

    function automatic logic [CBW-1:0] cb_store(input logic [CB_IN_W-1:0] c);
        logic [CBW+CB_IN_W-1:0] wide;
        wide = {{CBW{1'b0}}, c};
        return wide[CBW-1:0];
    endfunction

    function automatic logic [CB_IN_W-1:0] cb_out(input logic [CBW-1:0] c);
        logic [CBW+CB_IN_W-1:0] wide;
        wide = {{CB_IN_W{1'b0}}, c};
        return wide[CB_IN_W-1:0];
    endfunction

    // Entry index reduced modulo the pool depth, as a constant table
    logic [IDXW-1:0] mod_tab [2**ENTRY_W];

    for (genvar gi = 0; gi < 2**ENTRY_W; gi++)
    begin : g_mod
        assign mod_tab[gi] = IDXW'(gi % MAX_ENTRIES);
    end

    // Registers
    state_t                 state_reg, state_next;
    logic                   after_reg, after_next;
    logic                   present_reg, present_next;
    logic                   nofree_reg, nofree_next;
    logic [IDXW-1:0]        e_reg, e_next;
    logic [IDXW-1:0]        t_reg, t_next;
    logic [CBW-1:0]         cb_reg, cb_next;
    logic [LW-1:0]          save_reg, save_next;
    logic [LW-1:0]          save2_reg, save2_next;
    logic [LW-1:0]          free_reg, free_next;
    logic [LW-1:0]          first_reg, first_next;
    logic [LW-1:0]          last_reg, last_next;
    logic [IDXW-1:0]        cnt_reg, cnt_next;
    logic [IDXW-1:0]        cnt_last_reg, cnt_last_next;
    logic [POOL_CFG_W-1:0]  pool_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;
    logic [IDXW-1:0]        cur_addr_reg;
    logic                   fwd_hit_reg;
    logic [WORD_W-1:0]      fwd_data_reg;

    // RAM port signals
    logic [IDXW-1:0]        rd_addr;
    logic                   we;
    logic [WORD_W-1:0]      wr_word;
    logic [WORD_W-1:0]      ram_rdata;
    logic [WORD_W-1:0]      cur_word;
    logic [LW-1:0]          cur_next, cur_prev;
    logic [CBW-1:0]         cur_cb;

    // Init count
    logic [CW-1:0]          pool_ext, n_ext;
    logic [IDXW-1:0]        e_idx;
    logic                   accept;

    ltlm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cur_addr_reg),
        .wdata (wr_word),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Word of the entry read last cycle, with the same-cycle write forwarded
    assign cur_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign cur_next = cur_word[NEXT_LSB +: LW];
    assign cur_prev = cur_word[PREV_LSB +: LW];
    assign cur_cb   = cur_word[0 +: CBW];

    assign pool_ext  = CW'(pool_reg);
    assign n_ext     = (pool_ext > MAX_EXT) ? MAX_EXT : pool_ext;
    assign e_idx     = mod_tab[req.entry];
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= NIL;
            first_reg     <= NIL;
            last_reg      <= NIL;
            pool_reg      <= POOL_SIZE_RESET;
            rsp_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
            fwd_hit_reg   <= we && (cur_addr_reg == rd_addr);
            if (cfg_valid && cfg_ready)
            begin
                pool_reg <= cfg_data;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        after_reg    <= after_next;
        present_reg  <= present_next;
        nofree_reg   <= nofree_next;
        e_reg        <= e_next;
        t_reg        <= t_next;
        cb_reg       <= cb_next;
        save_reg     <= save_next;
        save2_reg    <= save2_next;
        cnt_reg      <= cnt_next;
        cnt_last_reg <= cnt_last_next;
        rsp_reg      <= rsp_next;
        cur_addr_reg <= rd_addr;
        fwd_data_reg <= wr_word;
    end

    // Sequencer: next state, RAM access and response
    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        present_next   = present_reg;
        nofree_next    = nofree_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        cb_next        = cb_reg;
        save_next      = save_reg;
        save2_next     = save2_reg;
        free_next      = free_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        cnt_last_next  = cnt_last_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_addr        = cur_addr_reg;
        we             = 1'b0;
        wr_word        = cur_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    e_next       = e_idx;
                    t_next       = e_idx;
                    cb_next      = cb_store(req.callback_id);
                    present_next = req.entry_present;
                    after_next   = (req.cmd == CMD_INS_AFTER);
                    nofree_next  = 1'b0;
                    rd_addr      = e_idx;
                    case (req.cmd)
                        CMD_INIT:
                        begin
                            if (n_ext != '0)
                            begin
                                cnt_next      = '0;
                                cnt_last_next = IDXW'(n_ext - CW'(1));
                                rd_addr       = '0;
                                state_next    = ST_INIT;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        CMD_INS_BEFORE, CMD_INS_AFTER:
                        begin
                            if (!is_idx(free_reg))
                            begin
                                nofree_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                t_next     = free_reg[IDXW-1:0];
                                rd_addr    = free_reg[IDXW-1:0];
                                state_next = ST_INS_T;
                            end
                        end
                        CMD_REMOVE: state_next = ST_RM_T;
                        CMD_MARK:   state_next = ST_MARK;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end

            // Link the pool into the free list, one entry a cycle
            ST_INIT:
            begin
                we = 1'b1;
                if (cnt_reg == cnt_last_reg)
                begin
                    wr_word[NEXT_LSB +: LW] = NIL;
                    free_next  = '0;
                    first_next = NIL;
                    last_next  = NIL;
                    rd_addr    = t_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    wr_word[NEXT_LSB +: LW] = idx2link(IDXW'(cnt_reg + 1'b1));
                    cnt_next   = IDXW'(cnt_reg + 1'b1);
                    rd_addr    = IDXW'(cnt_reg + 1'b1);
                end
            end

            // New entry: pop free list, store callback, point at neighbor or stand alone if none
            ST_INS_T:
            begin
                we        = 1'b1;
                free_next = cur_next;
                wr_word[0 +: CBW] = cb_reg;
                if (!present_reg)
                begin
                    wr_word[NEXT_LSB +: LW] = NIL;
                    wr_word[PREV_LSB +: LW] = NIL;
                    first_next = idx2link(t_reg);
                    last_next  = idx2link(t_reg);
                    rd_addr    = t_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    if (after_reg)
                    begin
                        wr_word[PREV_LSB +: LW] = idx2link(e_reg);
                    end
                    else
                    begin
                        wr_word[NEXT_LSB +: LW] = idx2link(e_reg);
                    end
                    rd_addr    = e_reg;
                    state_next = ST_INS_E;
                end
            end

            // Neighbor: save its far link, point it at the new entry
            ST_INS_E:
            begin
                we = 1'b1;
                if (after_reg)
                begin
                    save_next = cur_next;
                    wr_word[NEXT_LSB +: LW] = idx2link(t_reg);
                end
                else
                begin
                    save_next = cur_prev;
                    wr_word[PREV_LSB +: LW] = idx2link(t_reg);
                end
                rd_addr    = t_reg;
                state_next = ST_INS_T2;
            end

            // New entry: take over the neighbor's old far link
            ST_INS_T2:
            begin
                we = 1'b1;
                if (after_reg)
                begin
                    wr_word[NEXT_LSB +: LW] = (t_reg == e_reg) ? idx2link(t_reg) : save_reg;
                end
                else
                begin
                    wr_word[PREV_LSB +: LW] = (t_reg == e_reg) ? idx2link(t_reg) : save_reg;
                end
                if (is_idx(save_reg))
                begin
                    rd_addr    = save_reg[IDXW-1:0];
                    state_next = ST_INS_NB;
                end
                else
                begin
                    if (after_reg)
                    begin
                        last_next = idx2link(t_reg);
                    end
                    else
                    begin
                        first_next = idx2link(t_reg);
                    end
                    rd_addr    = t_reg;
                    state_next = ST_FIN;
                end
            end

            // Far neighbor: point back at the new entry
            ST_INS_NB:
            begin
                we = 1'b1;
                if (after_reg)
                begin
                    wr_word[PREV_LSB +: LW] = idx2link(t_reg);
                end
                else
                begin
                    wr_word[NEXT_LSB +: LW] = idx2link(t_reg);
                end
                rd_addr    = t_reg;
                state_next = ST_FIN;
            end

            // Remove: fetch both links of the entry
            ST_RM_T:
            begin
                save_next  = cur_next;
                save2_next = cur_prev;
                if (is_idx(cur_next))
                begin
                    rd_addr    = cur_next[IDXW-1:0];
                    state_next = ST_RM_N;
                end
                else
                begin
                    last_next = cur_prev;
                    if (is_idx(cur_prev))
                    begin
                        rd_addr    = cur_prev[IDXW-1:0];
                        state_next = ST_RM_P;
                    end
                    else
                    begin
                        first_next = cur_next;
                        rd_addr    = t_reg;
                        state_next = ST_RM_F;
                    end
                end
            end

            // Successor takes the removed entry's prev link
            ST_RM_N:
            begin
                we = 1'b1;
                wr_word[PREV_LSB +: LW] = save2_reg;
                if (is_idx(save2_reg))
                begin
                    rd_addr    = save2_reg[IDXW-1:0];
                    state_next = ST_RM_P;
                end
                else
                begin
                    first_next = save_reg;
                    rd_addr    = t_reg;
                    state_next = ST_RM_F;
                end
            end

            // Predecessor takes the removed entry's next link
            ST_RM_P:
            begin
                we = 1'b1;
                wr_word[NEXT_LSB +: LW] = save_reg;
                rd_addr    = t_reg;
                state_next = ST_RM_F;
            end

            // Push the removed entry onto the free list
            ST_RM_F:
            begin
                we = 1'b1;
                wr_word[0 +: CBW]       = '0;
                wr_word[NEXT_LSB +: LW] = free_reg;
                free_next  = idx2link(t_reg);
                rd_addr    = t_reg;
                state_next = ST_FIN;
            end

            ST_MARK:
            begin
                we = 1'b1;
                wr_word[0 +: CBW] = REMOVE_CODE;
                rd_addr    = t_reg;
                state_next = ST_FIN;
            end

            // Build the response beat from the entry's final word
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = nofree_reg;
                    rsp_next.task_res   = nofree_reg ? '0 : link6(idx2link(t_reg));
                    rsp_next.head       = is_idx(first_reg) ? link6(first_reg) : '0;
                    rsp_next.head_valid = is_idx(first_reg);
                    rsp_next.tail       = is_idx(last_reg) ? link6(last_reg) : '0;
                    rsp_next.prev_valid = !nofree_reg && is_idx(cur_prev);
                    rsp_next.link_prev  = (!nofree_reg && is_idx(cur_prev)) ?
                                          link6(cur_prev) : '0;
                    rsp_next.next_valid = !nofree_reg && is_idx(cur_next);
                    rsp_next.link_next  = (!nofree_reg && is_idx(cur_next)) ?
                                          link6(cur_next) : '0;
                    rsp_next.entry_callback = nofree_reg ? '0 : cb_out(cur_cb);
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/task_list_checker.sv =====
// task_list_checker: watches the request, response and pool-size channels of the
// linked task list manager, predicts every response beat and compares it. Uses ltlm_pkg.
`timescale 1ns / 1ps

module task_list_checker
    import ltlm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [POOL_CFG_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    beats_checked
);

    localparam int         NUM_ENTRIES = 64;
    localparam logic [6:0] NULL_LINK   = 7'd64;
    localparam logic [3:0] REMOVE_CODE = 4'hF;
    localparam int         MAX_REPORTS = 100;

    typedef logic [6:0] link_t;

    // One owed response beat; the known bits mask fields read from never-written words
    typedef struct packed {
        rsp_t beat;
        logic prev_known;
        logic next_known;
        logic cb_known;
    } owed_rsp_t;

    // Shadow pool: links, callbacks and which words have been written so far
    link_t                 next_of [NUM_ENTRIES];
    link_t                 prev_of [NUM_ENTRIES];
    logic [3:0]            cb_of   [NUM_ENTRIES];
    bit                    next_set [NUM_ENTRIES];
    bit                    prev_set [NUM_ENTRIES];
    bit                    cb_set   [NUM_ENTRIES];
    link_t                 free_top;
    link_t                 list_head;
    link_t                 list_tail;
    logic [POOL_CFG_W-1:0] pool_cfg;
    owed_rsp_t             owed_q [$];

    function automatic logic [5:0] link_idx(link_t l);
        return l[6] ? 6'd0 : l[5:0];
    endfunction

    // Apply one command to the shadow pool and build the beat it must produce
    function automatic owed_rsp_t predict_task_cmd(req_t r);
        owed_rsp_t  o;
        logic [5:0] e;
        logic [5:0] t;
        link_t      nb;
        link_t      p;
        link_t      n;
        link_t      cnt;
        logic       no_free;
        int         i;
        e       = r.entry;
        t       = e;
        no_free = 1'b0;
        nb      = r.entry_present ? {1'b0, e} : NULL_LINK;
        case (r.cmd)
            CMD_INIT:
            begin
                // size zero leaves everything alone; oversize saturates to the pool
                if (pool_cfg != 0)
                begin
                    cnt = (pool_cfg > NULL_LINK) ? NULL_LINK : pool_cfg;
                    for (i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (i < cnt)
                        begin
                            next_of[i]  = (i + 1 < cnt) ? link_t'(i + 1) : NULL_LINK;
                            next_set[i] = 1'b1;
                        end
                    end
                    free_top  = 7'd0;
                    list_head = NULL_LINK;
                    list_tail = NULL_LINK;
                end
            end
            CMD_INS_BEFORE, CMD_INS_AFTER:
            begin
                if (free_top[6])
                begin
                    no_free = 1'b1;
                end
                else
                begin
                    t         = free_top[5:0];
                    cb_of[t]  = r.callback_id;
                    cb_set[t] = 1'b1;
                    free_top  = next_of[t];
                    if (nb[6])
                    begin
                        // null neighbor: new entry becomes the whole active list
                        next_of[t]  = NULL_LINK;
                        prev_of[t]  = NULL_LINK;
                        next_set[t] = 1'b1;
                        prev_set[t] = 1'b1;
                        list_head   = {1'b0, t};
                        list_tail   = {1'b0, t};
                    end
                    else if (r.cmd == CMD_INS_BEFORE)
                    begin
                        next_of[t]  = nb;
                        next_set[t] = 1'b1;
                        p           = prev_of[e];
                        prev_of[t]  = p;
                        prev_set[t] = prev_set[e];
                        if (p[6])
                        begin
                            list_head = {1'b0, t};
                        end
                        else
                        begin
                            next_of[p[5:0]]  = {1'b0, t};
                            next_set[p[5:0]] = 1'b1;
                        end
                        prev_of[e]  = {1'b0, t};
                        prev_set[e] = 1'b1;
                    end
                    else
                    begin
                        prev_of[t]  = nb;
                        prev_set[t] = 1'b1;
                        n           = next_of[e];
                        next_of[t]  = n;
                        next_set[t] = next_set[e];
                        if (n[6])
                        begin
                            list_tail = {1'b0, t};
                        end
                        else
                        begin
                            prev_of[n[5:0]]  = {1'b0, t};
                            prev_set[n[5:0]] = 1'b1;
                        end
                        next_of[e]  = {1'b0, t};
                        next_set[e] = 1'b1;
                    end
                end
            end
            CMD_REMOVE:
            begin
                // unlinked blindly from the stored links, then pushed on the free list
                n = next_of[e];
                p = prev_of[e];
                if (n[6])
                begin
                    list_tail = p;
                end
                else
                begin
                    prev_of[n[5:0]]  = p;
                    prev_set[n[5:0]] = prev_set[e];
                end
                if (p[6])
                begin
                    list_head = n;
                end
                else
                begin
                    next_of[p[5:0]]  = n;
                    next_set[p[5:0]] = next_set[e];
                end
                cb_of[e]    = 4'd0;
                cb_set[e]   = 1'b1;
                next_of[e]  = free_top;
                next_set[e] = 1'b1;
                free_top    = {1'b0, e};
            end
            CMD_MARK:
            begin
                cb_of[e]  = REMOVE_CODE;
                cb_set[e] = 1'b1;
            end
            default:
            begin
                // query and the two spare codes change nothing
            end
        endcase

        o                 = '0;
        o.beat.status     = no_free;
        o.beat.head       = link_idx(list_head);
        o.beat.head_valid = !list_head[6];
        o.beat.tail       = link_idx(list_tail);
        o.prev_known      = 1'b1;
        o.next_known      = 1'b1;
        o.cb_known        = 1'b1;
        if (!no_free)
        begin
            o.beat.task_res       = t;
            o.beat.link_prev      = link_idx(prev_of[t]);
            o.beat.prev_valid     = !prev_of[t][6];
            o.beat.link_next      = link_idx(next_of[t]);
            o.beat.next_valid     = !next_of[t][6];
            o.beat.entry_callback = cb_of[t];
            o.prev_known          = prev_set[t];
            o.next_known          = next_set[t];
            o.cb_known            = cb_set[t];
        end
        return o;
    endfunction

    task automatic compare_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // Compare response beats, track pool size writes, predict accepted requests
    always @(posedge clk or negedge rst_n)
    begin : monitor
        owed_rsp_t want;
        int        i;
        if (!rst_n)
        begin
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                next_set[i] = 1'b0;
                prev_set[i] = 1'b0;
                cb_set[i]   = 1'b0;
            end
            free_top      = NULL_LINK;
            list_head     = NULL_LINK;
            list_tail     = NULL_LINK;
            pool_cfg      = POOL_SIZE_RESET;
            owed_q.delete();
            errors        = 0;
            pending       = 0;
            beats_checked = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: response beat with no request outstanding: %h", $time, rsp);
                end
                else
                begin
                    want = owed_q.pop_front();
                    beats_checked++;
                    compare_field("status", want.beat.status, rsp.status);
                    compare_field("task_res", want.beat.task_res, rsp.task_res);
                    compare_field("head", want.beat.head, rsp.head);
                    compare_field("head_valid", want.beat.head_valid, rsp.head_valid);
                    compare_field("tail", want.beat.tail, rsp.tail);
                    if (want.prev_known)
                    begin
                        compare_field("link_prev", want.beat.link_prev, rsp.link_prev);
                        compare_field("prev_valid", want.beat.prev_valid, rsp.prev_valid);
                    end
                    if (want.next_known)
                    begin
                        compare_field("link_next", want.beat.link_next, rsp.link_next);
                        compare_field("next_valid", want.beat.next_valid, rsp.next_valid);
                    end
                    if (want.cb_known)
                    begin
                        compare_field("entry_callback", want.beat.entry_callback,
                                      rsp.entry_callback);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pool_cfg = cfg_data;
            end
            if (req_valid && !req_stall)
            begin
                owed_q.push_back(predict_task_cmd(req));
            end
            pending = owed_q.size();
        end
    end

endmodule

// ===== tb/linked_task_list_manager_test.sv =====
// linked_task_list_manager_test: drives commands and pool-size writes into the
// task list manager and gives the verdict. Uses ltlm_pkg and task_list_checker.
`timescale 1ns / 1ps

module linked_task_list_manager_test;
    import ltlm_pkg::*;

    // the two unused command codes behave as query
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    localparam int IDLE_LIMIT  = 5000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [POOL_CFG_W-1:0] cfg_data;

    int errors;
    int pending;
    int beats_checked;
    int burst_left  = 0;
    int idle_cycles = 0;
    int pool_writes = 0;
    int cmd_count [8];

    // pool sizes for the first phases: smallest, zero, oversize, full pool and neighbors
    logic [POOL_CFG_W-1:0] pool_plan [8] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd65,
                                              7'd3, 7'd16};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    linked_task_list_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    task_list_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    function automatic req_t make_cmd(logic [CMD_W-1:0] c, logic [ENTRY_W-1:0] e,
                                      logic present, logic [CB_IN_W-1:0] cb);
        req_t r;
        r.cmd           = c;
        r.entry         = e;
        r.entry_present = present;
        r.callback_id   = cb;
        return r;
    endfunction

    // Random command, mostly on live list entries; never reads a word that was never written
    function automatic req_t next_task_cmd(input bit init_only);
        req_t       r;
        logic [5:0] live [$];
        logic [6:0] w;
        int         roll;
        int         tries;
        bit         ok;
        w = chk.list_head;
        while (!w[6] && live.size() < 64 && chk.next_set[w[5:0]])
        begin
            live.push_back(w[5:0]);
            w = chk.next_of[w[5:0]];
        end
        roll = $urandom_range(0, 99);
        if (init_only || roll < 4)
            r.cmd = CMD_INIT;
        else if (roll < 28)
            r.cmd = CMD_INS_BEFORE;
        else if (roll < 52)
            r.cmd = CMD_INS_AFTER;
        else if (roll < 74)
            r.cmd = CMD_REMOVE;
        else if (roll < 84)
            r.cmd = CMD_MARK;
        else if (roll < 96)
            r.cmd = CMD_QUERY;
        else
            r.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        r.callback_id = $urandom_range(0, 15);
        if (r.cmd == CMD_INS_BEFORE || r.cmd == CMD_INS_AFTER)
            r.entry_present = ($urandom_range(0, 99) >= (live.size() > 0 ? 5 : 60));
        else
            r.entry_present = $urandom_range(0, 1);

        ok = 1'b0;
        for (tries = 0; tries < 32 && !ok; tries++)
        begin
            if (live.size() > 0 && $urandom_range(0, 99) < 85)
                r.entry = live[$urandom_range(0, live.size() - 1)];
            else
                r.entry = $urandom_range(0, 63);
            case (r.cmd)
                CMD_INS_BEFORE, CMD_INS_AFTER:
                    ok = chk.free_top[6] ||
                         (chk.next_set[chk.free_top[5:0]] &&
                          (!r.entry_present ||
                           (r.cmd == CMD_INS_BEFORE ? chk.prev_set[r.entry]
                                                    : chk.next_set[r.entry])));
                CMD_REMOVE, CMD_MARK:
                    ok = chk.next_set[r.entry] && chk.prev_set[r.entry];
                default:
                    ok = chk.next_set[r.entry] && chk.prev_set[r.entry] && chk.cb_set[r.entry];
            endcase
        end
        // nothing safe to touch: a fresh sole entry always is
        if (!ok)
        begin
            r.cmd           = CMD_INS_AFTER;
            r.entry_present = 1'b0;
        end
        return r;
    endfunction

    // Send one request beat; the sender runs in bursts separated by idle gaps
    task automatic send(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 8)
                                                      : $urandom_range(20, 80);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        cmd_count[r.cmd]++;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Pool size is only written with the block drained and idle
    task automatic set_pool(input logic [POOL_CFG_W-1:0] size);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_data  <= size;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        pool_writes++;
    endtask

    // Response stall pattern: changes mode after each span of random length
    initial
    begin : rsp_stall_gen
        int mode;
        int span;
        int k;
        rsp_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            span = $urandom_range(40, 300);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
                    STALL_PERIODIC: rsp_stall <= ((k % 7) < 3);
                    default:        rsp_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed list walk, then random phases at several pool sizes
    initial
    begin : stimulus
        int ph;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pool is empty before the first init: both inserts report no free entry
        send(make_cmd(CMD_INS_BEFORE, 6'd0, 1'b0, 4'd0));
        send(make_cmd(CMD_INS_AFTER, 6'd63, 1'b1, 4'd14));
        send(make_cmd(CMD_INIT, 6'd0, 1'b0, 4'd0));
        // build 2,0,3,1 with callback fifteen and zero stored
        send(make_cmd(CMD_INS_AFTER, 6'd0, 1'b0, 4'd15));
        send(make_cmd(CMD_INS_AFTER, 6'd0, 1'b1, 4'd1));
        send(make_cmd(CMD_INS_BEFORE, 6'd0, 1'b1, 4'd14));
        send(make_cmd(CMD_INS_BEFORE, 6'd1, 1'b1, 4'd0));
        send(make_cmd(CMD_QUERY, 6'd3, 1'b0, 4'd0));
        send(make_cmd(CMD_SPARE_A, 6'd1, 1'b1, 4'd5));
        send(make_cmd(CMD_SPARE_B, 6'd2, 1'b0, 4'd10));
        send(make_cmd(CMD_MARK, 6'd3, 1'b0, 4'd0));
        // remove head, tail, then the same entry again while it sits on the free list
        send(make_cmd(CMD_REMOVE, 6'd2, 1'b0, 4'd0));
        send(make_cmd(CMD_REMOVE, 6'd1, 1'b0, 4'd0));
        send(make_cmd(CMD_REMOVE, 6'd2, 1'b1, 4'd0));
        // null neighbor drops whatever was active
        send(make_cmd(CMD_INS_BEFORE, 6'd0, 1'b0, 4'd7));
        send(make_cmd(CMD_QUERY, 6'd0, 1'b1, 4'd0));
        // neighbor not on the list, at the top index
        send(make_cmd(CMD_INS_AFTER, 6'd63, 1'b1, 4'd9));
        send(make_cmd(CMD_QUERY, 6'd1, 1'b0, 4'd0));

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_pool(ph < 8 ? pool_plan[ph] : POOL_CFG_W'($urandom_range(1, 64)));
            send(next_task_cmd(1'b1));
            repeat (PHASE_ITEMS) send(next_task_cmd(1'b0));
        end

        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Run covered %0d commands: %0d init, %0d insert, %0d remove, %0d mark, %0d query",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3] + cmd_count[4] +
                 cmd_count[5] + cmd_count[6] + cmd_count[7], cmd_count[0],
                 cmd_count[1] + cmd_count[2], cmd_count[3], cmd_count[4],
                 cmd_count[5] + cmd_count[6] + cmd_count[7]);
        $display("%0d pool size writes, %0d response beats compared, %0d mismatches",
                 pool_writes, beats_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ltlm_pkg.sv
rtl/ltlm_ram.sv
rtl/linked_task_list_manager.sv
tb/task_list_checker.sv
tb/linked_task_list_manager_test.sv
